/* rtl/tcw_pkg.sv */
// shared types and constants of the text console writer
package tcw_pkg;

  // action codes
  localparam logic [2:0] ACT_PUT  = 3'd0;
  localparam logic [2:0] ACT_BS   = 3'd1;
  localparam logic [2:0] ACT_CLR  = 3'd2;
  localparam logic [2:0] ACT_SET  = 3'd3;
  localparam logic [2:0] ACT_READ = 3'd4;

  // character codes
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BLANK = 8'h20;

  // register indexes and reset values
  localparam logic       CFG_FG     = 1'b0;
  localparam logic       CFG_BG     = 1'b1;
  localparam logic [3:0] FG_RESET   = 4'd7;
  localparam logic [3:0] BG_RESET   = 4'd0;
  localparam logic [7:0] ATTR_RESET = {BG_RESET, FG_RESET};

  // cell store write source
  typedef enum logic [2:0] {
    W_NONE,
    W_CHAR,
    W_BS,
    W_FILL,
    W_COPY,
    W_INIT
  } tcw_wsel_t;

  // cursor update
  typedef enum logic [2:0] {
    C_HOLD,
    C_ADV,
    C_NL,
    C_CR,
    C_BS,
    C_SET,
    C_SCROLL,
    C_ZERO
  } tcw_curop_t;

  typedef struct packed {
    logic       ld_item;
    logic       ld_res;
    tcw_wsel_t  wsel;
    logic       rd_pos;
    logic       rd_scroll;
    tcw_curop_t cur_op;
    logic       idx_clr;
    logic       idx_inc;
    logic       conv_step;
  } tcw_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       is_nl;
    logic       is_cr;
    logic       is_print;
    logic       pos_ok;
    logic       at_end;
    logic       cur_zero;
    logic       idx_last;
    logic       in_copy;
    logic       conv_done;
  } tcw_sts_t;

endpackage

/* rtl/text_console_writer.sv */
// top level of the text console writer
//
// A character-cell screen store of ROWS x COLUMNS cells (char byte low, attribute
// byte high) with a cursor. One input transaction (action, char_code, position)
// gives exactly one result transaction (cursor_cell, read_char, read_attr,
// accepted). Both channels use valid/stall; cfg_we writes fg_color (index 0) or
// bg_color (index 1) at once.
//
// The item is taken in S_IDLE or S_FIN, decoded in S_DEC, and the result register
// loads in S_FIN. A new input is taken in the cycle the result loads, so no new
// item is taken before the result of the last one loads. Put char, backspace, read
// and invalid actions go straight from S_DEC to S_FIN. Set cursor, clear and scroll
// run longer, set by the walk of the single-write cell store or the row search: set
// cursor steps down the rows of the new position in S_CONV, clear blanks every cell
// in S_CLR, and a scroll (put char or newline past the last cell) reads and writes
// each moved cell in S_SCRD and S_SCWR, then blanks the freed rows.
// Reset is synchronous; afterwards a clearing pass over all ROWS*COLUMNS cells fills
// the store with blanks of attribute 0x07 while in_stall stays high.
// A stalled result stays in the output register; the next item is worked on, and
// its result waits until the held one is taken.
module text_console_writer #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int SCROLL_ROWS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_char_code,
  input  logic [11:0] in_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_cursor_cell,
  output logic [7:0]  out_read_char,
  output logic [7:0]  out_read_attr,
  output logic        out_accepted,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  tcw_pkg::tcw_cmd_t cmd;
  tcw_pkg::tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_dp #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .SCROLL_ROWS (SCROLL_ROWS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_char_code    (in_char_code),
    .in_position     (in_position),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_cursor_cell (out_cursor_cell),
    .out_read_char   (out_read_char),
    .out_read_attr   (out_read_attr),
    .out_accepted    (out_accepted)
  );

endmodule

/* rtl/tcw_ctrl.sv */
// controller state machine of the text console writer
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_INIT = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_DEC  = 8'b0000_0100,
    S_SCRD = 8'b0000_1000,
    S_SCWR = 8'b0001_0000,
    S_CLR  = 8'b0010_0000,
    S_CONV = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    case (state_r)
      S_INIT: begin
        // clearing pass after reset
        cmd.wsel    = tcw_pkg::W_INIT;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_FIN;
        case (sts.act)
          tcw_pkg::ACT_PUT: begin
            if (sts.is_nl || sts.is_print) begin
              if (sts.at_end) begin
                // scroll first, then come back here
                cmd.cur_op  = tcw_pkg::C_SCROLL;
                cmd.idx_clr = 1'b1;
                state_nxt   = S_SCRD;
              end else if (sts.is_print) begin
                cmd.wsel   = tcw_pkg::W_CHAR;
                cmd.cur_op = tcw_pkg::C_ADV;
              end else begin
                cmd.cur_op = tcw_pkg::C_NL;
              end
            end else if (sts.is_cr) begin
              cmd.cur_op = tcw_pkg::C_CR;
            end
          end
          tcw_pkg::ACT_BS: begin
            if (!sts.cur_zero) begin
              cmd.wsel   = tcw_pkg::W_BS;
              cmd.cur_op = tcw_pkg::C_BS;
            end
          end
          tcw_pkg::ACT_CLR: begin
            cmd.cur_op  = tcw_pkg::C_ZERO;
            cmd.idx_clr = 1'b1;
            state_nxt   = S_CLR;
          end
          tcw_pkg::ACT_SET: begin
            if (sts.pos_ok) begin
              state_nxt = S_CONV;
            end
          end
          tcw_pkg::ACT_READ: begin
            cmd.rd_pos = sts.pos_ok;
          end
          default: ;
        endcase
      end
      S_SCRD: begin
        if (sts.in_copy) begin
          cmd.rd_scroll = 1'b1;
          state_nxt     = S_SCWR;
        end else begin
          cmd.wsel    = tcw_pkg::W_FILL;
          cmd.idx_inc = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_DEC;
          end
        end
      end
      S_SCWR: begin
        cmd.wsel    = tcw_pkg::W_COPY;
        cmd.idx_inc = 1'b1;
        state_nxt   = sts.idx_last ? S_DEC : S_SCRD;
      end
      S_CLR: begin
        cmd.wsel    = tcw_pkg::W_FILL;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_FIN;
        end
      end
      S_CONV: begin
        // row of the new position by repeated subtraction
        if (sts.conv_done) begin
          cmd.cur_op = tcw_pkg::C_SET;
          state_nxt  = S_FIN;
        end else begin
          cmd.conv_step = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          in_stall      = 1'b0;
          cmd.ld_res    = 1'b1;
          out_valid_nxt = 1'b1;
          if (in_valid) begin
            cmd.ld_item = 1'b1;
            state_nxt   = S_DEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/tcw_dp.sv */
// datapath of the text console writer: cell store, cursor, item and result registers
module tcw_dp #(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int SCROLL_ROWS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        in_action,
  input  logic [7:0]        in_char_code,
  input  logic [11:0]       in_position,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [3:0]        cfg_data,
  input  tcw_pkg::tcw_cmd_t cmd,
  output tcw_pkg::tcw_sts_t sts,
  output logic [10:0]       out_cursor_cell,
  output logic [7:0]        out_read_char,
  output logic [7:0]        out_read_attr,
  output logic              out_accepted
);

  localparam int CELL       = ROWS * COLUMNS;
  localparam int SCROLL_EFF = (SCROLL_ROWS < ROWS) ? SCROLL_ROWS : ROWS;
  localparam int SHIFT      = SCROLL_EFF * COLUMNS;
  localparam int COPY_CNT   = CELL - SHIFT;
  localparam int ADDR_W     = $clog2(CELL);
  localparam int CUR_W      = $clog2(CELL + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam int PW         = (CUR_W > 12) ? CUR_W : 12;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

  logic [15:0]       mem [CELL];
  logic [15:0]       rdata_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0]       wdata;

  logic [2:0]        act_r;
  logic [7:0]        ch_r;
  logic [11:0]       pos_r;
  logic [3:0]        fg_r, bg_r;
  logic [7:0]        attr;

  logic [CUR_W-1:0]  cur_r, cur_nxt, cur_dec;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [11:0]       rem_r, rem_nxt;
  logic [ROW_W-1:0]  crow_r, crow_nxt;

  logic [10:0]       res_cursor_r;
  logic [7:0]        res_char_r, res_attr_r;
  logic              res_ok_r;
  logic              rd_hit;

  assign attr    = {bg_r, fg_r};
  assign cur_dec = cur_r - 1'b1;

  // status to the controller
  always_comb begin
    sts.act       = act_r;
    sts.is_nl     = (ch_r == tcw_pkg::CH_NL);
    sts.is_cr     = (ch_r == tcw_pkg::CH_CR);
    sts.is_print  = (ch_r >= tcw_pkg::CH_BLANK);
    sts.pos_ok    = (PW'(pos_r) < PW'(CELL));
    sts.at_end    = (cur_r == CUR_W'(CELL));
    sts.cur_zero  = (cur_r == '0);
    sts.idx_last  = (idx_r == ADDR_W'(CELL - 1));
    sts.in_copy   = (idx_r < ADDR_W'(COPY_CNT));
    sts.conv_done = (rem_r < 12'(COLUMNS));
  end

  // cursor kept both as a cell index and as row and column
  always_comb begin
    cur_nxt = cur_r;
    row_nxt = row_r;
    col_nxt = col_r;
    case (cmd.cur_op)
      tcw_pkg::C_ADV: begin
        cur_nxt = cur_r + 1'b1;
        if (col_r == COL_LAST) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      tcw_pkg::C_NL: begin
        cur_nxt = cur_r - CUR_W'(col_r) + CUR_W'(COLUMNS);
        row_nxt = row_r + 1'b1;
        col_nxt = '0;
      end
      tcw_pkg::C_CR: begin
        cur_nxt = cur_r - CUR_W'(col_r);
        col_nxt = '0;
      end
      tcw_pkg::C_BS: begin
        cur_nxt = cur_dec;
        if (col_r == '0) begin
          col_nxt = COL_LAST;
          row_nxt = row_r - 1'b1;
        end else begin
          col_nxt = col_r - 1'b1;
        end
      end
      tcw_pkg::C_SET: begin
        cur_nxt = CUR_W'(pos_r);
        row_nxt = crow_r;
        col_nxt = COL_W'(rem_r);
      end
      tcw_pkg::C_SCROLL: begin
        if (row_r >= ROW_W'(SCROLL_EFF)) begin
          cur_nxt = cur_r - CUR_W'(SHIFT);
          row_nxt = row_r - ROW_W'(SCROLL_EFF);
        end else begin
          cur_nxt = '0;
          row_nxt = '0;
          col_nxt = '0;
        end
      end
      tcw_pkg::C_ZERO: begin
        cur_nxt = '0;
        row_nxt = '0;
        col_nxt = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    rem_nxt  = rem_r;
    crow_nxt = crow_r;
    if (cmd.ld_item) begin
      rem_nxt  = in_position;
      crow_nxt = '0;
    end else if (cmd.conv_step) begin
      rem_nxt  = rem_r - 12'(COLUMNS);
      crow_nxt = crow_r + 1'b1;
    end
  end

  // cell store write and read ports
  always_comb begin
    mem_we = 1'b1;
    waddr  = idx_r;
    wdata  = {attr, tcw_pkg::CH_BLANK};
    case (cmd.wsel)
      tcw_pkg::W_CHAR: begin
        waddr = ADDR_W'(cur_r);
        wdata = {attr, ch_r};
      end
      tcw_pkg::W_BS: begin
        waddr = ADDR_W'(cur_dec);
      end
      tcw_pkg::W_FILL: ;
      tcw_pkg::W_COPY: begin
        wdata = rdata_r;
      end
      tcw_pkg::W_INIT: begin
        wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::CH_BLANK};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re = cmd.rd_pos || cmd.rd_scroll;
  assign raddr  = cmd.rd_pos ? ADDR_W'(pos_r) : (idx_r + ADDR_W'(SHIFT));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      row_r <= '0;
      col_r <= '0;
      idx_r <= '0;
      fg_r  <= tcw_pkg::FG_RESET;
      bg_r  <= tcw_pkg::BG_RESET;
    end else begin
      cur_r <= cur_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      idx_r <= idx_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tcw_pkg::CFG_FG: fg_r <= cfg_data;
          tcw_pkg::CFG_BG: bg_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign rd_hit = (act_r == tcw_pkg::ACT_READ) && sts.pos_ok;

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    crow_r <= crow_nxt;
    if (cmd.ld_item) begin
      act_r <= in_action;
      ch_r  <= in_char_code;
      pos_r <= in_position;
    end
    if (cmd.ld_res) begin
      res_cursor_r <= 11'(cur_r);
      res_char_r   <= rd_hit ? rdata_r[7:0] : 8'd0;
      res_attr_r   <= rd_hit ? rdata_r[15:8] : 8'd0;
      res_ok_r     <= !(((act_r == tcw_pkg::ACT_SET) || (act_r == tcw_pkg::ACT_READ))
                        && !sts.pos_ok);
    end
  end

  assign out_cursor_cell = res_cursor_r;
  assign out_read_char   = res_char_r;
  assign out_read_attr   = res_attr_r;
  assign out_accepted    = res_ok_r;

endmodule

/* rtl/tcw_checker.sv */
// port checker of the text console writer and its bind
module tcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] out_cursor_cell,
  input logic [7:0]  out_read_char,
  input logic [7:0]  out_read_attr,
  input logic        out_accepted
);

  // reset starts the clearing pass with no result pending
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not busy or result pending after reset");

  // one item at a time: busy right after a transaction is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken in the cycle after a transaction");

  // a rejected item never reports cell contents
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_read_char == 8'd0 && out_read_attr == 8'd0)
    else $error("rejected item reports cell data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cursor_cell)
      && $stable(out_read_char) && $stable(out_read_attr) && $stable(out_accepted))
    else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
